FILE: hdl/hrd_pkg.sv
`timescale 1ns / 1ps
package hrd_pkg;

    // Item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam int COEF_IDX_W = 4;
    localparam int NUM_COEF   = 9;

    // Row-major coefficient positions
    localparam logic [COEF_IDX_W-1:0] H11 = 4'd0;
    localparam logic [COEF_IDX_W-1:0] H12 = 4'd1;
    localparam logic [COEF_IDX_W-1:0] H13 = 4'd2;
    localparam logic [COEF_IDX_W-1:0] H21 = 4'd3;
    localparam logic [COEF_IDX_W-1:0] H22 = 4'd4;
    localparam logic [COEF_IDX_W-1:0] H23 = 4'd5;
    localparam logic [COEF_IDX_W-1:0] H31 = 4'd6;
    localparam logic [COEF_IDX_W-1:0] H32 = 4'd7;
    localparam logic [COEF_IDX_W-1:0] H33 = 4'd8;

    // Depth of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic push;
        logic full;
    } hrd_queue_wr_t;

endpackage

FILE: hdl/hrd_front.sv
`timescale 1ns / 1ps
module hrd_front
    import hrd_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int LW = 66
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [COEF_IDX_W-1:0] coef_index,
    input  logic signed [W-1:0]   coef_value,
    input  logic signed [W-1:0]   src_x,
    input  logic signed [W-1:0]   src_y,
    input  logic signed [W-1:0]   tgt_x,
    input  logic signed [W-1:0]   tgt_y,
    output hrd_queue_wr_t         wr,
    input  logic                  q_full,
    output logic signed [LW-1:0]  num_x,
    output logic signed [LW-1:0]  num_y,
    output logic signed [LW-1:0]  den,
    output logic signed [W-1:0]   q_tgt_x,
    output logic signed [W-1:0]   q_tgt_y
);

    logic signed [W-1:0]   coef_reg [NUM_COEF];
    logic                  valid_reg;
    logic                  valid_next;
    logic signed [2*W-1:0] p11_reg, p12_reg, p21_reg, p22_reg, p31_reg, p32_reg;
    logic signed [W-1:0]   c13_reg, c23_reg, c33_reg;
    logic signed [W-1:0]   tx_reg, ty_reg;
    logic                  accept;
    logic                  push;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign wr.push  = push;
    assign wr.full  = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (accept && cmd == CMD_LOAD && coef_index < COEF_IDX_W'(NUM_COEF))
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept && cmd == CMD_POINT)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Products use the store as it stands when the point is taken
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_POINT)
        begin
            p11_reg <= coef_reg[H11] * src_x;
            p12_reg <= coef_reg[H12] * src_y;
            p21_reg <= coef_reg[H21] * src_x;
            p22_reg <= coef_reg[H22] * src_y;
            p31_reg <= coef_reg[H31] * src_x;
            p32_reg <= coef_reg[H32] * src_y;
            c13_reg <= coef_reg[H13];
            c23_reg <= coef_reg[H23];
            c33_reg <= coef_reg[H33];
            tx_reg  <= tgt_x;
            ty_reg  <= tgt_y;
        end
    end

    assign num_x   = LW'(p11_reg) + LW'(p12_reg) + (LW'(c13_reg) <<< F);
    assign num_y   = LW'(p21_reg) + LW'(p22_reg) + (LW'(c23_reg) <<< F);
    assign den     = LW'(p31_reg) + LW'(p32_reg) + (LW'(c33_reg) <<< F);
    assign q_tgt_x = tx_reg;
    assign q_tgt_y = ty_reg;

endmodule

FILE: hdl/hrd_queue.sv
`timescale 1ns / 1ps
module hrd_queue
    import hrd_pkg::*;
#(
    parameter int DW = 262
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  hrd_queue_wr_t wr,
    input  logic [DW-1:0] wr_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output logic [DW-1:0] rd_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;

    assign do_push = wr.push && !wr.full;
    assign full    = count_reg == CW'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/hrd_back.sv
`timescale 1ns / 1ps
module hrd_back
    import hrd_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int LW = 66
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic signed [LW-1:0] num_x,
    input  logic signed [LW-1:0] num_y,
    input  logic signed [LW-1:0] den,
    input  logic signed [W-1:0]  tgt_x,
    input  logic signed [W-1:0]  tgt_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [W-1:0]         distance,
    output logic                 denom_zero,
    output logic                 saturated
);

    localparam int RW  = LW + F + W;   // divider remainder
    localparam int SW  = 2 * W + 2;    // sum of squares
    localparam int RMW = W + 4;        // root remainder

    logic en;

    // ---------------- divider pipeline, index 0 is the entry stage
    logic          dv_valid_reg [0:W];
    logic [RW-1:0] dv_rx_reg    [0:W];
    logic [RW-1:0] dv_ry_reg    [0:W];
    logic [RW-1:0] dv_d_reg     [0:W];
    logic [W-1:0]  dv_qx_reg    [0:W];
    logic [W-1:0]  dv_qy_reg    [0:W];
    logic          dv_negx_reg  [0:W];
    logic          dv_negy_reg  [0:W];
    logic          dv_ovfx_reg  [0:W];
    logic          dv_ovfy_reg  [0:W];
    logic          dv_zero_reg  [0:W];
    logic [W-1:0]  dv_tx_reg    [0:W];
    logic [W-1:0]  dv_ty_reg    [0:W];

    logic [LW-1:0] mag_nx, mag_ny, mag_d;
    logic [RW-1:0] n_x, n_y, d_w;

    assign en    = !out_valid || !out_stall;
    assign q_pop = en && !q_empty;

    assign mag_nx = num_x[LW-1] ? LW'(-num_x) : LW'(num_x);
    assign mag_ny = num_y[LW-1] ? LW'(-num_y) : LW'(num_y);
    assign mag_d  = den[LW-1]   ? LW'(-den)   : LW'(den);
    assign n_x    = RW'(mag_nx) << F;
    assign n_y    = RW'(mag_ny) << F;
    assign d_w    = RW'(mag_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= q_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dv_rx_reg[0]   <= n_x;
            dv_ry_reg[0]   <= n_y;
            dv_d_reg[0]    <= d_w;
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_negx_reg[0] <= num_x[LW-1] ^ den[LW-1];
            dv_negy_reg[0] <= num_y[LW-1] ^ den[LW-1];
            dv_ovfx_reg[0] <= n_x >= (d_w << W);
            dv_ovfy_reg[0] <= n_y >= (d_w << W);
            dv_zero_reg[0] <= den == '0;
            dv_tx_reg[0]   <= tgt_x;
            dv_ty_reg[0]   <= tgt_y;
        end
    end

    // One quotient bit per stage, MSB first
    for (genvar k = 0; k < W; k++)
    begin : g_div
        localparam int SH = W - 1 - k;
        logic [RW-1:0] trial;
        logic          ge_x, ge_y;

        assign trial = dv_d_reg[k] << SH;
        assign ge_x  = dv_rx_reg[k] >= trial;
        assign ge_y  = dv_ry_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rx_reg[k+1]   <= ge_x ? dv_rx_reg[k] - trial : dv_rx_reg[k];
                dv_ry_reg[k+1]   <= ge_y ? dv_ry_reg[k] - trial : dv_ry_reg[k];
                dv_qx_reg[k+1]   <= {dv_qx_reg[k][W-2:0], ge_x};
                dv_qy_reg[k+1]   <= {dv_qy_reg[k][W-2:0], ge_y};
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_negx_reg[k+1] <= dv_negx_reg[k];
                dv_negy_reg[k+1] <= dv_negy_reg[k];
                dv_ovfx_reg[k+1] <= dv_ovfx_reg[k];
                dv_ovfy_reg[k+1] <= dv_ovfy_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_tx_reg[k+1]   <= dv_tx_reg[k];
                dv_ty_reg[k+1]   <= dv_ty_reg[k];
            end
        end
    end

    // ---------------- clamp, difference
    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]        lim_x, lim_y, qc_x, qc_y;
    logic                sat_x, sat_y;
    logic signed [W+1:0] m_x, m_y, dx, dy;

    assign lim_x = dv_negx_reg[W] ? LIM_NEG : LIM_POS;
    assign lim_y = dv_negy_reg[W] ? LIM_NEG : LIM_POS;
    assign sat_x = dv_ovfx_reg[W] || dv_qx_reg[W] > lim_x;
    assign sat_y = dv_ovfy_reg[W] || dv_qy_reg[W] > lim_y;
    assign qc_x  = sat_x ? lim_x : dv_qx_reg[W];
    assign qc_y  = sat_y ? lim_y : dv_qy_reg[W];
    assign m_x   = dv_negx_reg[W] ? -$signed({2'b00, qc_x}) : $signed({2'b00, qc_x});
    assign m_y   = dv_negy_reg[W] ? -$signed({2'b00, qc_y}) : $signed({2'b00, qc_y});
    assign dx    = (W+2)'($signed(dv_tx_reg[W])) - m_x;
    assign dy    = (W+2)'($signed(dv_ty_reg[W])) - m_y;

    logic         md_valid_reg, md_zero_reg, md_sat_reg;
    logic [W:0]   md_ax_reg, md_ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            md_valid_reg <= dv_valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_ax_reg   <= dx[W+1] ? (W+1)'(-dx) : dx[W:0];
            md_ay_reg   <= dy[W+1] ? (W+1)'(-dy) : dy[W:0];
            md_sat_reg  <= sat_x || sat_y;
            md_zero_reg <= dv_zero_reg[W];
        end
    end

    // ---------------- squares, then sum
    logic          sq_valid_reg, sq_zero_reg, sq_sat_reg;
    logic [SW-1:0] sq_x_reg, sq_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= md_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg    <= md_ax_reg * md_ax_reg;
            sq_y_reg    <= md_ay_reg * md_ay_reg;
            sq_sat_reg  <= md_sat_reg;
            sq_zero_reg <= md_zero_reg;
        end
    end

    // ---------------- square root, index 0 holds the sum
    logic           rt_valid_reg [0:W+1];
    logic [SW-1:0]  rt_n_reg     [0:W+1];
    logic [RMW-1:0] rt_rem_reg   [0:W+1];
    logic [W:0]     rt_root_reg  [0:W+1];
    logic           rt_sat_reg   [0:W+1];
    logic           rt_zero_reg  [0:W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            rt_valid_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_n_reg[0]    <= sq_x_reg + sq_y_reg;
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_sat_reg[0]  <= sq_sat_reg;
            rt_zero_reg[0] <= sq_zero_reg;
        end
    end

    // One root bit per stage from the top bit pair down
    for (genvar j = 0; j <= W; j++)
    begin : g_sqrt
        logic [RMW-1:0] rem_cat, trial;
        logic           ge;

        assign rem_cat = {rt_rem_reg[j][RMW-3:0], rt_n_reg[j][SW-1:SW-2]};
        assign trial   = {1'b0, rt_root_reg[j], 2'b01};
        assign ge      = rem_cat >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                rt_valid_reg[j+1] <= rt_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_n_reg[j+1]    <= rt_n_reg[j] << 2;
                rt_rem_reg[j+1]  <= ge ? rem_cat - trial : rem_cat;
                rt_root_reg[j+1] <= {rt_root_reg[j][W-1:0], ge};
                rt_sat_reg[j+1]  <= rt_sat_reg[j];
                rt_zero_reg[j+1] <= rt_zero_reg[j];
            end
        end
    end

    // ---------------- output register
    logic         out_valid_reg, dz_reg, sat_reg;
    logic [W-1:0] dist_reg;
    logic [W:0]   root_f;

    assign root_f = rt_root_reg[W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rt_valid_reg[W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rt_zero_reg[W+1])
            begin
                dist_reg <= '0;
                dz_reg   <= 1'b1;
                sat_reg  <= 1'b0;
            end
            else
            begin
                dist_reg <= root_f[W] ? {W{1'b1}} : root_f[W-1:0];
                dz_reg   <= 1'b0;
                sat_reg  <= rt_sat_reg[W+1] || root_f[W];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance   = dist_reg;
    assign denom_zero = dz_reg;
    assign saturated  = sat_reg;

endmodule

FILE: hdl/homography_reprojection_distance.sv
`timescale 1ns / 1ps
// Homography reprojection distance.
// Input channel (in_valid / in_stall): cmd 0 is a load transaction that writes
// coefficient coef_index (h11..h33, row-major) with coef_value; indexes above
// eight are dropped. cmd 1 is a point transaction: src is mapped through the
// stored homography with a projective divide and the distance to tgt returned.
// Output channel (out_valid / out_stall): one transaction per point, in order;
// loads give none. A zero denominator returns distance 0 with denom_zero set.
// Throughput: one transaction per cycle on both sides when nothing stalls.
// A point passes through one product stage, the queue, a divider of one
// quotient bit per stage (VALUE_WIDTH stages), clamp, squares, sum, a root of
// one bit per stage (VALUE_WIDTH + 1 stages) and the output register. A point
// uses the coefficients stored when it is accepted.
// Reset clears the coefficient store to zero and drops everything in flight.
// While out_valid is high, out_stall holds the whole back pipeline; the front
// keeps taking transactions until the queue fills, then raises in_stall.
module homography_reprojection_distance
    import hrd_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [COEF_IDX_W-1:0]         coef_index,
    input  logic signed [VALUE_WIDTH-1:0] coef_value,
    input  logic signed [VALUE_WIDTH-1:0] src_x,
    input  logic signed [VALUE_WIDTH-1:0] src_y,
    input  logic signed [VALUE_WIDTH-1:0] tgt_x,
    input  logic signed [VALUE_WIDTH-1:0] tgt_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [VALUE_WIDTH-1:0]        distance,
    output logic                          denom_zero,
    output logic                          saturated
);

    localparam int W  = VALUE_WIDTH;
    // Linear form width: products plus the shifted constant term, with headroom
    localparam int LW = ((W + FRAC_BITS > 2 * W) ? W + FRAC_BITS : 2 * W) + 2;
    localparam int DW = 3 * LW + 2 * W;

    hrd_queue_wr_t        wr;
    logic                 q_full, q_empty, q_pop;
    logic signed [LW-1:0] f_num_x, f_num_y, f_den;
    logic signed [W-1:0]  f_tx, f_ty;
    logic [DW-1:0]        q_wdata, q_rdata;
    logic signed [LW-1:0] b_num_x, b_num_y, b_den;
    logic signed [W-1:0]  b_tx, b_ty;

    // Front: coefficient store, classification, products and linear forms
    hrd_front #(.W(W), .F(FRAC_BITS), .LW(LW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .src_x      (src_x),
        .src_y      (src_y),
        .tgt_x      (tgt_x),
        .tgt_y      (tgt_y),
        .wr         (wr),
        .q_full     (q_full),
        .num_x      (f_num_x),
        .num_y      (f_num_y),
        .den        (f_den),
        .q_tgt_x    (f_tx),
        .q_tgt_y    (f_ty)
    );

    assign q_wdata = {f_num_x, f_num_y, f_den, f_tx, f_ty};

    hrd_queue #(.DW(DW)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_rdata)
    );

    assign {b_num_x, b_num_y, b_den, b_tx, b_ty} = q_rdata;

    // Back: divide, distance, root, output register
    hrd_back #(.W(W), .F(FRAC_BITS), .LW(LW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .num_x      (b_num_x),
        .num_y      (b_num_y),
        .den        (b_den),
        .tgt_x      (b_tx),
        .tgt_y      (b_ty),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .distance   (distance),
        .denom_zero (denom_zero),
        .saturated  (saturated)
    );

endmodule

FILE: bench/homography_reprojection_distance_test.sv
`timescale 1ns / 1ps
module homography_reprojection_distance_test;
    import hrd_pkg::*;

    localparam int FB = 16;
    localparam int VW = 32;
    // Allow slack for the tail wait.
    localparam int DRAIN_CYCLES = 4 * VW + 40;
    localparam int CYCLE_LIMIT = 400000;

    // Expected point transaction result
    typedef struct {
        logic [VW-1:0] dist_exp;
        logic          dz;
        logic          sat;
    } point_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [COEF_IDX_W-1:0] coef_index;
    logic signed [VW-1:0] coef_value;
    logic signed [VW-1:0] src_x;
    logic signed [VW-1:0] src_y;
    logic signed [VW-1:0] tgt_x;
    logic signed [VW-1:0] tgt_y;
    logic                 out_valid;
    logic                 out_stall;
    logic [VW-1:0]        distance;
    logic                 denom_zero;
    logic                 saturated;

    homography_reprojection_distance #(.FRAC_BITS(FB), .VALUE_WIDTH(VW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .coef_index(coef_index), .coef_value(coef_value),
        .src_x(src_x), .src_y(src_y), .tgt_x(tgt_x), .tgt_y(tgt_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .denom_zero(denom_zero), .saturated(saturated)
    );

    // Local copy of the coefficient store, tracking accepted loads.
    logic signed [VW-1:0] h_model [NUM_COEF];
    point_result_t        pending_results[$];

    int  error_count;
    int  cycle_count;
    int  points_sent;
    int  loads_sent;
    int  results_seen;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_receiver;     // long receiver hold-off, set by its own process

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, what, got, want);
    endtask

    // Exact rational mapping: numerator and denominator carry 2*FB fraction bits.
    function automatic logic signed [VW-1:0] mapped_coord(
        input logic signed [127:0] num, input logic signed [127:0] den,
        inout logic sat);
        logic         neg;
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic [127:0] lim;
        neg = num[127] != den[127];
        nm  = num[127] ? -num : num;
        dm  = den[127] ? -den : den;
        q   = (nm << FB) / dm;       // truncation toward zero on magnitudes
        lim = (128'd1 << (VW - 1)) - (neg ? 128'd0 : 128'd1);
        if (q > lim)
        begin
            sat = 1'b1;
            q   = lim;
        end
        return neg ? -q[VW-1:0] : q[VW-1:0];
    endfunction

    function automatic logic signed [127:0] row_sum(input int k,
        input logic signed [VW-1:0] x, input logic signed [VW-1:0] y);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        a = 128'(h_model[k]) * 128'(x);
        b = 128'(h_model[k+1]) * 128'(y);
        c = 128'(h_model[k+2]) <<< FB;
        return a + b + c;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic point_result_t reproject_point(
        input logic signed [VW-1:0] sx, input logic signed [VW-1:0] sy,
        input logic signed [VW-1:0] tx, input logic signed [VW-1:0] ty);
        point_result_t       r;
        logic signed [127:0] den;
        logic signed [VW-1:0] mx;
        logic signed [VW-1:0] my;
        logic signed [127:0] dx;
        logic signed [127:0] dy;
        logic [63:0]         root;
        logic                sat;
        sat = 1'b0;
        den = row_sum(6, sx, sy);
        if (den == 0)
        begin
            r.dist_exp = '0;
            r.dz       = 1'b1;
            r.sat      = 1'b0;
            return r;
        end
        mx   = mapped_coord(row_sum(0, sx, sy), den, sat);
        my   = mapped_coord(row_sum(3, sx, sy), den, sat);
        dx   = 128'(tx) - 128'(mx);
        dy   = 128'(ty) - 128'(my);
        root = floor_sqrt(dx * dx + dy * dy);
        if (root > 64'({VW{1'b1}}))
        begin
            root = 64'({VW{1'b1}});
            sat  = 1'b1;
        end
        r.dist_exp = root[VW-1:0];
        r.dz       = 1'b0;
        r.sat      = sat;
        return r;
    endfunction

    // Offer one transaction, wait for acceptance, update the model on accept.
    // Valid stays high after acceptance; idle gaps and drains drop it.
    task automatic send_item(input logic c, input logic [COEF_IDX_W-1:0] idx,
                             input logic [VW-1:0] cv, input logic [VW-1:0] sx,
                             input logic [VW-1:0] sy, input logic [VW-1:0] tx,
                             input logic [VW-1:0] ty);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        coef_index <= idx;
        coef_value <= cv;
        src_x      <= sx;
        src_y      <= sy;
        tgt_x      <= tx;
        tgt_y      <= ty;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge
        if (c == CMD_POINT)
        begin
            pending_results.push_back(reproject_point(sx, sy, tx, ty));
            points_sent++;
        end
        else
        begin
            if (idx < NUM_COEF)
                h_model[idx] = cv;
            loads_sent++;
        end
    endtask

    task automatic load_coef(input logic [COEF_IDX_W-1:0] idx, input logic [VW-1:0] v);
        send_item(CMD_LOAD, idx, v, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(input logic [VW-1:0] sx, input logic [VW-1:0] sy,
                              input logic [VW-1:0] tx, input logic [VW-1:0] ty);
        send_item(CMD_POINT, $urandom, $urandom, sx, sy, tx, ty);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random value with a bias toward small magnitudes and extremes.
    function automatic logic [VW-1:0] random_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {VW{1'b0}} | $urandom_range(4 << FB);
            2: return -($urandom_range(4 << FB));
            3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(512 << FB)) - (256 << FB);
        endcase
    endfunction

    task automatic load_identity_ish();
        load_coef(H11, (1 << FB) + $urandom_range(4096) - 2048);
        load_coef(H12, $urandom_range(8192) - 4096);
        load_coef(H13, random_value());
        load_coef(H21, $urandom_range(8192) - 4096);
        load_coef(H22, (1 << FB) + $urandom_range(4096) - 2048);
        load_coef(H23, random_value());
        load_coef(H31, $urandom_range(16) - 8);
        load_coef(H32, $urandom_range(16) - 8);
        load_coef(H33, 1 << FB);
    endtask

    // Extremes, zero denominator, ignored index, saturation.
    task automatic test_directed();
        send_point(32'h0001_0000, 32'h0002_0000, 0, 0);        // all-zero store
        load_coef(4'd9, 32'h1234_5678);                        // ignored index
        load_coef(4'd15, 32'hffff_ffff);
        load_coef(H33, 1 << FB);
        load_coef(H11, 1 << FB);
        load_coef(H22, 1 << FB);
        send_point(32'h0003_0000, 32'h0004_0000, 0, 0);        // distance 5
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        load_coef(H11, 32'h7fff_ffff);
        load_coef(H12, 32'h8000_0000);
        load_coef(H13, 32'h7fff_ffff);
        load_coef(H33, 1);                                     // tiny denominator
        send_point(32'h7fff_ffff, 32'h0001_0000, 0, 0);
        send_point(32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
        load_coef(H31, 1 << FB);
        load_coef(H33, -(1 << FB));
        send_point(32'h0001_0000, 32'h0000_0000, 0, 0);        // denominator zero
        send_point(32'h0000_0000, 32'hffff_0000, 0, 0);        // negative denominator
        load_coef(H23, 32'h8000_0000);
        load_coef(H32, 32'h7fff_ffff);
        send_point(32'h0002_0000, 32'h0001_0000, 32'h5555_5555, 32'haaaa_aaaa);
        wait_drained();
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(39) == 0)
                load_identity_ish();
            else if ($urandom_range(9) == 0)
                send_item(CMD_LOAD, $urandom_range(15), random_value(),
                          $urandom, $urandom, $urandom, $urandom);
            else
                send_point(random_value(), random_value(), random_value(), random_value());
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipeline.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        load_identity_ish();
        fork
            begin
                hold_receiver = 1'b1;
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            for (int i = 0; i < 120; i++)
                send_point(random_value(), random_value(), random_value(), random_value());
        join
        wait_drained();
    endtask

    // Sender pauses after each burst until every result has come back.
    task automatic test_burst_drain();
        sender_idle_pct    = 10;
        receiver_stall_pct = 20;
        for (int b = 0; b < 5; b++)
        begin
            repeat (8)
                send_point(random_value(), random_value(), random_value(), random_value());
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
        wait_drained();
    endtask

    // Receiver stall driver
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_receiver || ($urandom_range(99) < receiver_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        point_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", distance, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (distance !== want.dist_exp)
                    report_mismatch("distance", distance, want.dist_exp);
                if (denom_zero !== want.dz)
                    report_mismatch("denom_zero", denom_zero, want.dz);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        cmd                = CMD_LOAD;
        coef_index         = '0;
        coef_value         = '0;
        src_x              = '0;
        src_y              = '0;
        tgt_x              = '0;
        tgt_y              = '0;
        out_stall          = 1'b0;
        hold_receiver      = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        points_sent        = 0;
        loads_sent         = 0;
        results_seen       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < NUM_COEF; i++)
            h_model[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(120, 0, 0);
        test_random_phase(120, 70, 0);
        test_random_phase(120, 0, 70);
        test_random_phase(120, 35, 35);
        test_backpressure();
        test_burst_drain();

        $display("covered %0d point and %0d load transactions, %0d results checked",
                 points_sent, loads_sent, results_seen);
        $display("phases: directed, idle/stall mixes, long hold-off, drain bursts");
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
